// ===== hdl/c_source_tokenizer_macros.svh =====
// Assertion macros shared by the tokenizer modules
`ifndef C_SOURCE_TOKENIZER_MACROS_SVH
`define C_SOURCE_TOKENIZER_MACROS_SVH
`define CST_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define CST_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ===== hdl/cst_pkg.sv =====
// Package with token kinds, scan modes and character helpers for the tokenizer
package cst_pkg;

  localparam int KindW = 4;
  localparam logic [KindW-1:0] KIND_DATATYPE = 4'd0;
  localparam logic [KindW-1:0] KIND_IDENT    = 4'd1;
  localparam logic [KindW-1:0] KIND_CHAR     = 4'd2;
  localparam logic [KindW-1:0] KIND_STRING   = 4'd3;
  localparam logic [KindW-1:0] KIND_SPECIAL  = 4'd4;
  localparam logic [KindW-1:0] KIND_ARITH    = 4'd5;
  localparam logic [KindW-1:0] KIND_LOGIC    = 4'd6;
  localparam logic [KindW-1:0] KIND_REL      = 4'd7;
  localparam logic [KindW-1:0] KIND_ASSIGN   = 4'd8;
  localparam logic [KindW-1:0] KIND_OTHER    = 4'd9;
  localparam logic [KindW-1:0] KIND_NUMBER   = 4'd10;
  localparam logic [KindW-1:0] KIND_KEYWORD  = 4'd11;
  localparam logic [KindW-1:0] KIND_END      = 4'd12;

  localparam logic [3:0] M_IDLE      = 4'd0;
  localparam logic [3:0] M_SLASH     = 4'd1;
  localparam logic [3:0] M_LINECOM   = 4'd2;
  localparam logic [3:0] M_BLOCK     = 4'd3;
  localparam logic [3:0] M_BLOCKSTAR = 4'd4;
  localparam logic [3:0] M_STR       = 4'd5;
  localparam logic [3:0] M_STRESC    = 4'd6;
  localparam logic [3:0] M_CHR       = 4'd7;
  localparam logic [3:0] M_CHRESC    = 4'd8;
  localparam logic [3:0] M_NUM       = 4'd9;
  localparam logic [3:0] M_WORD      = 4'd10;
  localparam logic [3:0] M_OP        = 4'd11;

  localparam int KwCount = 32;
  localparam int KwChars = 8;

  // Number of result slots a single item may produce
  localparam int MaxRes = 2;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
  endfunction

  function automatic logic is_special(input logic [7:0] c);
    return c == "[" || c == "]" || c == "(" || c == ")" || c == "{" ||
           c == "}" || c == "," || c == ";" || c == ":" || c == "?";
  endfunction

  function automatic logic is_opchar(input logic [7:0] c);
    return c == "=" || c == "!" || c == "<" || c == ">" || c == "*" ||
           c == "%" || c == "+" || c == "-" || c == "&" || c == "|";
  endfunction

  function automatic logic [KindW-1:0] op_single(input logic [7:0] op);
    logic [KindW-1:0] k;
    case (op)
      "=": k = KIND_ASSIGN;
      "!": k = KIND_LOGIC;
      "<", ">": k = KIND_REL;
      "*", "%", "+", "-": k = KIND_ARITH;
      default: k = KIND_OTHER;
    endcase
    return k;
  endfunction

  // Pair kind; ok low when op,c is no pair
  function automatic logic [KindW:0] op_pair(input logic [7:0] op, input logic [7:0] c);
    logic [KindW:0] r;
    r = '0;
    if (c == "=") begin
      if (op == "=" || op == "!" || op == "<" || op == ">") r = {1'b1, KIND_REL};
      else if (op == "*" || op == "%" || op == "+" || op == "-") r = {1'b1, KIND_ASSIGN};
    end else if (c == op) begin
      if (op == "<" || op == ">" || op == "+" || op == "-") r = {1'b1, KIND_OTHER};
      else if (op == "&" || op == "|") r = {1'b1, KIND_LOGIC};
    end else if (op == "-" && c == ">") begin
      r = {1'b1, KIND_OTHER};
    end
    return r;
  endfunction

  typedef logic [8*KwChars-1:0] kw_word_t;

  // Keyword text, first character in the low byte
  function automatic kw_word_t kw_text(input int i);
    kw_word_t w;
    logic [63:0] s;
    case (i)
      0: s = "auto"; 1: s = "break"; 2: s = "case"; 3: s = "char";
      4: s = "const"; 5: s = "continue"; 6: s = "default"; 7: s = "do";
      8: s = "double"; 9: s = "else"; 10: s = "enum"; 11: s = "extern";
      12: s = "float"; 13: s = "for"; 14: s = "goto"; 15: s = "if";
      16: s = "int"; 17: s = "long"; 18: s = "register"; 19: s = "return";
      20: s = "short"; 21: s = "signed"; 22: s = "sizeof"; 23: s = "static";
      24: s = "struct"; 25: s = "switch"; 26: s = "typedef"; 27: s = "union";
      28: s = "unsigned"; 29: s = "void"; 30: s = "volatile"; default: s = "while";
    endcase
    w = '0;
    for (int b = 0; b < 8; b++) begin
      w[8*b +: 8] = s[8*(7-b) +: 8];
    end
    // left-justify: string literal right-aligned, shift out leading zeros
    for (int b = 0; b < 8; b++) begin
      if (w[7:0] == 8'h00) w = w >> 8;
    end
    return w;
  endfunction

  function automatic logic [3:0] kw_len(input int i);
    kw_word_t w;
    logic [3:0] n;
    w = kw_text(i);
    n = '0;
    for (int b = 0; b < 8; b++) begin
      if (w[8*b +: 8] != 8'h00) n = n + 4'd1;
    end
    return n;
  endfunction

  function automatic logic kw_is_type(input int i);
    return i == 3 || i == 8 || i == 10 || i == 12 || i == 16 || i == 17 ||
           i == 20 || i == 21 || i == 24 || i == 28 || i == 29;
  endfunction

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [15:0]      line;
    logic [15:0]      column;
    logic [7:0]       length;
  } token_t;

  // Classified result set of one item
  typedef struct packed {
    logic [1:0]  count;
    logic        word_pending;
    token_t      tok0;
    token_t      tok1;
  } res_set_t;

endpackage

// ===== hdl/cst_front.sv =====
// Front part: scan state machine, classifies each byte into up to two tokens
module cst_front #(
  parameter int MATCH_CHARS   = 8,
  parameter int POSITION_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [7:0]          in_char_i,
  input  logic                end_of_input_i,
  output logic                valid_o,
  output cst_pkg::res_set_t   res_o,
  output logic [8*MATCH_CHARS-1:0] prefix_o
);
  import cst_pkg::*;

  localparam logic [POSITION_BITS-1:0] PosMax = '1;
  localparam int LenIdxW = $clog2(MATCH_CHARS);

  logic [3:0]               mode_q, mode_d;
  logic [POSITION_BITS-1:0] line_q, line_d, col_q, col_d;
  logic [POSITION_BITS-1:0] sline_q, sline_d, scol_q, scol_d;
  logic [7:0]               len_q, len_d;
  logic [8*MATCH_CHARS-1:0] pre_q, pre_d;
  logic [7:0]               op_q, op_d;
  res_set_t                 res;
  logic [8*MATCH_CHARS-1:0] wpre;

  function automatic logic [15:0] out16(input logic [POSITION_BITS-1:0] v);
    logic [15:0] r;
    r = ((v >> 16) != '0) ? 16'hffff : 16'(v);
    return r;
  endfunction

  function automatic logic [POSITION_BITS-1:0] sinc(input logic [POSITION_BITS-1:0] v);
    return (v < PosMax) ? v + 1'b1 : PosMax;
  endfunction

  always_comb begin
    logic [POSITION_BITS-1:0] cl;
    logic afresh;
    logic [KindW:0] pr;
    logic [7:0] c;
    token_t t;
    mode_d = mode_q; line_d = line_q; col_d = col_q;
    sline_d = sline_q; scol_d = scol_q; len_d = len_q;
    pre_d = pre_q; op_d = op_q;
    res = '0; wpre = pre_q;
    c = in_char_i;
    cl = sinc(col_q);
    afresh = 1'b0;
    pr = '0;
    t = '0;
    t.line = out16(sline_q); t.column = out16(scol_q);
    if (end_of_input_i) begin
      t.length = len_q;
      case (mode_q)
        M_SLASH: begin t.kind = KIND_ARITH; t.length = 8'd1; res.count = 2'd1; end
        M_STR, M_STRESC: begin t.kind = KIND_STRING; res.count = 2'd1; end
        M_CHR, M_CHRESC: begin t.kind = KIND_CHAR; res.count = 2'd1; end
        M_NUM: begin t.kind = KIND_NUMBER; res.count = 2'd1; end
        M_WORD: begin t.kind = KIND_IDENT; res.count = 2'd1; res.word_pending = 1'b1; end
        M_OP: begin t.kind = op_single(op_q); t.length = 8'd1; res.count = 2'd1; end
        default: ;
      endcase
      res.tok0 = t;
      res.tok1.kind = KIND_END;
      res.tok1.line = out16(line_q);
      res.tok1.column = out16(cl);
      res.tok1.length = '0;
      if (res.count == 2'd0) res.tok0 = res.tok1;
      res.count = res.count + 2'd1;
      mode_d = M_IDLE; line_d = POSITION_BITS'(1); col_d = '0;
      sline_d = '0; scol_d = '0; len_d = '0; pre_d = '0; op_d = '0;
    end else begin
      case (mode_q)
        M_SLASH: begin
          mode_d = M_IDLE;
          if (c == "/") mode_d = M_LINECOM;
          else if (c == "*") mode_d = M_BLOCK;
          else begin
            t.kind = (c == "=") ? KIND_ASSIGN : KIND_ARITH;
            t.length = (c == "=") ? 8'd2 : 8'd1;
            res.tok0 = t; res.count = 2'd1;
            afresh = (c != "=");
          end
        end
        M_LINECOM: if (c == 8'h0a) mode_d = M_IDLE;
        M_BLOCK: if (c == "*") mode_d = M_BLOCKSTAR;
        M_BLOCKSTAR: begin
          if (c == "/") mode_d = M_IDLE;
          else if (c != "*") mode_d = M_BLOCK;
        end
        M_STR, M_CHR: begin
          if (c == ((mode_q == M_STR) ? 8'h22 : 8'h27)) begin
            t.kind = (mode_q == M_STR) ? KIND_STRING : KIND_CHAR;
            t.length = len_q;
            res.tok0 = t; res.count = 2'd1;
            mode_d = M_IDLE;
          end else begin
            if (len_q == 8'd0) begin sline_d = line_q; scol_d = cl; end
            if (len_q != 8'hff) len_d = len_q + 8'd1;
            if (c == 8'h5c) mode_d = (mode_q == M_STR) ? M_STRESC : M_CHRESC;
          end
        end
        M_STRESC, M_CHRESC: begin
          if (len_q == 8'd0) begin sline_d = line_q; scol_d = cl; end
          if (len_q != 8'hff) len_d = len_q + 8'd1;
          mode_d = (mode_q == M_STRESC) ? M_STR : M_CHR;
        end
        M_NUM: begin
          if (is_alpha(c) || is_digit(c)) begin
            if (len_q != 8'hff) len_d = len_q + 8'd1;
          end else begin
            t.kind = KIND_NUMBER; t.length = len_q;
            res.tok0 = t; res.count = 2'd1; mode_d = M_IDLE; afresh = 1'b1;
          end
        end
        M_WORD: begin
          if (is_alpha(c) || is_digit(c)) begin
            if (len_q < 8'(MATCH_CHARS)) pre_d[8*len_q[LenIdxW-1:0] +: 8] = c;
            if (len_q != 8'hff) len_d = len_q + 8'd1;
          end else begin
            t.kind = KIND_IDENT; t.length = len_q;
            res.tok0 = t; res.count = 2'd1; res.word_pending = 1'b1;
            mode_d = M_IDLE; afresh = 1'b1;
          end
        end
        M_OP: begin
          mode_d = M_IDLE;
          pr = op_pair(op_q, c);
          t.kind = pr[KindW] ? pr[KindW-1:0] : op_single(op_q);
          t.length = pr[KindW] ? 8'd2 : 8'd1;
          res.tok0 = t; res.count = 2'd1;
          afresh = !pr[KindW];
        end
        default: afresh = 1'b1;
      endcase
      if (afresh) begin
        sline_d = line_q; scol_d = cl; len_d = '0; mode_d = M_IDLE;
        t = '0; t.line = out16(line_q); t.column = out16(cl); t.length = 8'd1;
        if (c == 8'h22 || c == 8'h27) begin
          mode_d = (c == 8'h22) ? M_STR : M_CHR; scol_d = sinc(cl);
        end else if (c == "/") mode_d = M_SLASH;
        else if (is_special(c) || c == "^" || c == "~" || c == ".") begin
          t.kind = is_special(c) ? KIND_SPECIAL : KIND_OTHER;
          if (res.count == 2'd0) res.tok0 = t; else res.tok1 = t;
          res.count = res.count + 2'd1;
        end else if (is_digit(c)) begin mode_d = M_NUM; len_d = 8'd1; end
        else if (is_alpha(c)) begin
          mode_d = M_WORD; pre_d = '0; pre_d[7:0] = c; len_d = 8'd1;
        end else if (is_opchar(c)) begin mode_d = M_OP; op_d = c; end
      end
      if (c == 8'h0a) begin line_d = sinc(line_q); col_d = '0; end
      else col_d = cl;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE; line_q <= POSITION_BITS'(1); col_q <= '0;
      sline_q <= '0; scol_q <= '0; len_q <= '0; pre_q <= '0; op_q <= '0;
    end else if (valid_i) begin
      mode_q <= mode_d; line_q <= line_d; col_q <= col_d;
      sline_q <= sline_d; scol_q <= scol_d; len_q <= len_d;
      pre_q <= pre_d; op_q <= op_d;
    end
  end

  assign valid_o  = valid_i && (res.count != 2'd0);
  assign res_o    = res;
  assign prefix_o = wpre;
endmodule

// ===== hdl/cst_queue.sv =====
// Short queue of classified result sets between front and back
module cst_queue #(
  parameter int MATCH_CHARS = 8,
  parameter int DEPTH       = 4
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  cst_pkg::res_set_t        res_i,
  input  logic [8*MATCH_CHARS-1:0] prefix_i,
  output logic                     full_o,
  output logic                     valid_o,
  input  logic                     pop_i,
  output cst_pkg::res_set_t        res_o,
  output logic [8*MATCH_CHARS-1:0] prefix_o
);
  import cst_pkg::*;
  `include "c_source_tokenizer_macros.svh"

  localparam int AW = $clog2(DEPTH);

  res_set_t                 res_mem [DEPTH];
  logic [8*MATCH_CHARS-1:0] pre_mem [DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [AW:0]   cnt_q;

  assign full_o  = cnt_q == (AW+1)'(DEPTH);
  assign valid_o = cnt_q != '0;
  assign res_o    = res_mem[rd_q];
  assign prefix_o = pre_mem[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      res_mem[wr_q] <= res_i;
      pre_mem[wr_q] <= prefix_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i && !full_o) wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
      if (pop_i && valid_o) rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push_i && !full_o) - (AW+1)'(pop_i && valid_o);
    end
  end

  `CST_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q <= (AW+1)'(DEPTH), "queue count overflow")
  `CST_ASSERT(a_empty_ptr, clk_i, rst_ni, cnt_q == '0 |-> wr_q == rd_q, "empty queue pointers differ")
  `CST_ASSERT(a_cnt_step, clk_i, rst_ni, (push_i && !full_o && !(pop_i && valid_o)) |=> cnt_q == $past(cnt_q) + 1'b1, "queue count did not grow")
endmodule

// ===== hdl/cst_back.sv =====
// Back part: keyword match on words and delivery of tokens one at a time
module cst_back #(
  parameter int MATCH_CHARS = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  cst_pkg::res_set_t        res_i,
  input  logic [8*MATCH_CHARS-1:0] prefix_i,
  output logic                     pop_o,
  output logic                     empty_o,
  input  logic                     pop_i,
  output logic [3:0]               token_kind_o,
  output logic [15:0]              token_line_o,
  output logic [15:0]              token_column_o,
  output logic [7:0]               token_length_o,
  output logic                     last_of_run_o
);
  import cst_pkg::*;
  `include "c_source_tokenizer_macros.svh"

  logic     idx_q;
  token_t   cur;
  logic [KindW-1:0] wkind;

  always_comb begin
    logic hit, typ;
    hit = 1'b0; typ = 1'b0;
    for (int i = 0; i < KwCount; i++) begin
      if (!hit && res_i.tok0.length == 8'(kw_len(i)) &&
          prefix_i[8*KwChars-1:0] == kw_text(i)) begin
        hit = 1'b1; typ = kw_is_type(i);
      end
    end
    if (hit) wkind = typ ? KIND_DATATYPE : KIND_KEYWORD;
    else if (res_i.tok0.length == 8'd4 && prefix_i[31:0] == {"L", "L", "U", "N"})
      wkind = KIND_CHAR;
    else wkind = KIND_IDENT;
  end

  always_comb begin
    cur = idx_q ? res_i.tok1 : res_i.tok0;
    if (!idx_q && res_i.word_pending) cur.kind = wkind;
  end

  assign empty_o        = !valid_i;
  assign token_kind_o   = cur.kind;
  assign token_line_o   = cur.line;
  assign token_column_o = cur.column;
  assign token_length_o = cur.length;
  assign last_of_run_o  = idx_q || res_i.count == 2'd1;
  assign pop_o          = valid_i && pop_i && last_of_run_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) idx_q <= 1'b0;
    else if (valid_i && pop_i) idx_q <= !last_of_run_o;
  end

  `CST_ASSERT(a_idx_valid, clk_i, rst_ni, idx_q |-> valid_i && res_i.count == 2'd2, "second slot without pair")
  `CST_ASSERT(a_count_nz, clk_i, rst_ni, valid_i |-> res_i.count != 2'd0, "empty result set queued")
  `CST_ASSERT(a_hold_idx, clk_i, rst_ni, (idx_q && !pop_i) |=> idx_q, "slot index lost while stalled")
endmodule

// ===== hdl/c_source_tokenizer.sv =====
// Top level of the C source tokenizer
// channel | dir | handshake | payload
// input   | in  | push/full | in_char_i, end_of_input_i
// result  | out | pop/empty | token_kind_o, token_line_o, token_column_o,
//         |     |           | token_length_o, last_of_run_o
// One byte is accepted every cycle while the four-entry queue has room.
// A byte's first token shows once its result set is at the head of the queue.
// Tokens drain one per cycle while pop is high; a byte giving two tokens holds
// its queue entry for two pops.
// Reset clears scan state, line to one and the queue.
// full rises when four result sets wait, from result-side stalls or from runs
// of two-token bytes.
module c_source_tokenizer #(
  parameter int MATCH_CHARS   = 8,
  parameter int POSITION_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_char_i,
  input  logic        end_of_input_i,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  token_kind_o,
  output logic [15:0] token_line_o,
  output logic [15:0] token_column_o,
  output logic [7:0]  token_length_o,
  output logic        last_of_run_o
);
  import cst_pkg::*;

  logic                     acc, fv, qv, qpop;
  res_set_t                 fres, qres;
  logic [8*MATCH_CHARS-1:0] fpre, qpre;

  assign acc = push && !full;

  cst_front #(.MATCH_CHARS(MATCH_CHARS), .POSITION_BITS(POSITION_BITS)) u_front (
    .clk_i, .rst_ni, .valid_i(acc), .in_char_i, .end_of_input_i,
    .valid_o(fv), .res_o(fres), .prefix_o(fpre)
  );

  cst_queue #(.MATCH_CHARS(MATCH_CHARS), .DEPTH(4)) u_queue (
    .clk_i, .rst_ni, .push_i(fv), .res_i(fres), .prefix_i(fpre), .full_o(full),
    .valid_o(qv), .pop_i(qpop), .res_o(qres), .prefix_o(qpre)
  );

  cst_back #(.MATCH_CHARS(MATCH_CHARS)) u_back (
    .clk_i, .rst_ni, .valid_i(qv), .res_i(qres), .prefix_i(qpre), .pop_o(qpop),
    .empty_o(empty), .pop_i(pop), .token_kind_o, .token_line_o, .token_column_o,
    .token_length_o, .last_of_run_o
  );
endmodule
